FILE: rtl/sme_pkg.sv
// Package for the stack-machine executor: payload structs, opcode and status codes,
// controller state type and the command/status structs between the controller and the datapath.
// No dependencies.
package sme_pkg;

    localparam int DATA_W        = 64;
    localparam int CFG_W         = 11;
    localparam int NEXT_PC_W     = 10;
    localparam int STACK_DEPTH_D = 64;
    localparam int PROG_DEPTH_D  = 1024;

    localparam logic [3:0] OP_PRINT = 4'd0;
    localparam logic [3:0] OP_PUSH  = 4'd1;
    localparam logic [3:0] OP_EXIT  = 4'd2;
    localparam logic [3:0] OP_POP   = 4'd3;
    localparam logic [3:0] OP_ADD   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_EQ    = 4'd6;
    localparam logic [3:0] OP_NEQ   = 4'd7;
    localparam logic [3:0] OP_DUP   = 4'd8;
    localparam logic [3:0] OP_JMP   = 4'd9;
    localparam logic [3:0] OP_JMPZ  = 4'd10;
    localparam logic [3:0] OP_WRITE = 4'd11;
    localparam logic [3:0] OP_WCHAR = 4'd12;

    localparam logic [1:0] EMIT_NONE  = 2'd0;
    localparam logic [1:0] EMIT_PRINT = 2'd1;
    localparam logic [1:0] EMIT_WRITE = 2'd2;
    localparam logic [1:0] EMIT_CHAR  = 2'd3;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_EXIT    = 3'd1,
        STS_UNDER   = 3'd2,
        STS_ADDR    = 3'd3,
        STS_DIVZ    = 3'd4,
        STS_OVER    = 3'd5,
        STS_BADOP   = 3'd6,
        STS_STOPPED = 3'd7
    } t_status;

    typedef struct packed {
        logic [3:0]               opcode;
        logic signed [DATA_W-1:0] argument;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic [NEXT_PC_W-1:0]     next_pc;
        logic [1:0]               emit_kind;
        logic signed [DATA_W-1:0] emit_value;
        logic signed [DATA_W-1:0] top_value;
    } t_out_item;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_DIV,
        CS_RETIRE
    } t_ctl_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic retire;
    } t_dp_cmd;

    typedef struct packed {
        logic div_need;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: rtl/sme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sme_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sme_div.sv
// Iterative signed 64-bit divider, one quotient bit per cycle, truncating toward zero.
// Depends on sme_pkg.
module sme_div
    import sme_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quo
);

    localparam int CW = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_quo;
    logic [DATA_W-1:0] r_den;
    logic              r_neg;
    logic [DATA_W:0]   sh;
    logic [DATA_W:0]   diff;
    logic              ge;

    assign sh   = {r_rem, r_quo[DATA_W-1]};
    assign diff = sh - {1'b0, r_den};
    assign ge   = !diff[DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(DATA_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // operands as magnitudes; MIN stays 2^63 as an unsigned value
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num[DATA_W-1] ? (DATA_W'(0) - i_num) : i_num;
            r_den <= i_den[DATA_W-1] ? (DATA_W'(0) - i_den) : i_den;
            r_rem <= '0;
            r_neg <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? diff[DATA_W-1:0] : sh[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

endmodule

FILE: rtl/sme_ctrl.sv
// Controller FSM for the stack-machine executor: sequences accept, execute, divide and retire.
// Depends on sme_pkg.
module sme_ctrl
    import sme_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_ctl_state r_state;
    t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            CS_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = CS_EXEC;
                end
            end
            CS_EXEC: begin
                if (i_stat.div_need) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = CS_DIV;
                end else begin
                    n_state = CS_RETIRE;
                end
            end
            CS_DIV: begin
                if (i_stat.div_done) begin
                    n_state = CS_RETIRE;
                end
            end
            CS_RETIRE: begin
                if (i_stat.out_free) begin
                    o_cmd.retire = 1'b1;
                    n_state      = CS_IDLE;
                end
            end
            default: n_state = CS_IDLE;
        endcase
    end

endmodule

FILE: rtl/sme_datapath.sv
// Datapath: instruction latch, stack RAM with cached top word, pc, stopped flag, status
// decode, divider and the output register. Depends on sme_pkg, sme_ram, sme_div.
module sme_datapath
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_D,
    parameter int PROGRAM_DEPTH = PROG_DEPTH_D
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_item         i_in_data,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = $clog2(PROGRAM_DEPTH);

    logic [3:0]        r_op;
    logic [DATA_W-1:0] r_arg;
    logic [DW-1:0]     r_depth;
    logic [PW-1:0]     r_pc;
    logic              r_stopped;
    logic [DATA_W-1:0] r_top;
    logic [CFG_W-1:0]  r_prog_len;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] quo;
    logic              div_done;
    logic [AW-1:0]     below_addr;
    logic              has1;
    logic              has2;
    logic              full;
    logic              tgt_ok;
    logic [PW-1:0]     pc_inc;

    t_status           sts;
    logic [PW-1:0]     pc_n;
    logic [1:0]        kind;
    logic [DATA_W-1:0] emit;
    logic [DATA_W-1:0] top_n;
    logic [DW-1:0]     depth_n;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] bin_res;
    logic              out_free;

    // read port always points at the word under the top
    assign below_addr = AW'(r_depth - DW'(2));

    sme_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.retire && we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (below_addr),
        .o_rdata (rdata)
    );

    sme_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (rdata),
        .i_den   (r_top),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign has1   = r_depth != '0;
    assign has2   = r_depth > DW'(1);
    assign full   = r_depth == DW'(STACK_DEPTH);
    assign tgt_ok = !r_arg[DATA_W-1] && (r_arg < DATA_W'(r_prog_len))
                    && (r_arg < DATA_W'(PROGRAM_DEPTH));
    assign pc_inc = (r_pc == PW'(PROGRAM_DEPTH - 1)) ? '0 : r_pc + PW'(1);

    always_comb begin
        case (r_op)
            OP_ADD:  bin_res = r_top + rdata;
            OP_DIV:  bin_res = quo;
            OP_EQ:   bin_res = DATA_W'(r_top == rdata);
            default: bin_res = DATA_W'(r_top != rdata);
        endcase
    end

    always_comb begin
        sts     = STS_OK;
        pc_n    = pc_inc;
        kind    = EMIT_NONE;
        emit    = '0;
        top_n   = r_top;
        depth_n = r_depth;
        we      = 1'b0;
        waddr   = AW'(r_depth);
        wdata   = r_arg;
        if (r_stopped) begin
            sts = STS_STOPPED;
        end else begin
            case (r_op) inside
                OP_PRINT, OP_WRITE, OP_WCHAR: begin
                    if (!has1) begin
                        sts = STS_UNDER;
                    end else if (r_op == OP_PRINT) begin
                        kind = EMIT_PRINT;
                        emit = r_top;
                    end else if (r_op == OP_WRITE) begin
                        kind = EMIT_WRITE;
                        emit = r_top;
                    end else begin
                        kind = EMIT_CHAR;
                        emit = {{(DATA_W-8){1'b0}}, r_top[7:0]};
                    end
                end
                OP_PUSH: begin
                    if (full) begin
                        sts = STS_OVER;
                    end else begin
                        we      = 1'b1;
                        top_n   = r_arg;
                        depth_n = r_depth + DW'(1);
                    end
                end
                OP_EXIT: begin
                    if (!has1) sts = STS_UNDER;
                    else sts = STS_EXIT;
                end
                OP_POP: begin
                    if (!has1) begin
                        sts = STS_UNDER;
                    end else begin
                        top_n   = has2 ? rdata : '0;
                        depth_n = r_depth - DW'(1);
                    end
                end
                OP_ADD, OP_DIV, OP_EQ, OP_NEQ: begin
                    if (!has2) begin
                        sts = STS_UNDER;
                    end else if (r_op == OP_DIV && r_top == '0) begin
                        sts = STS_DIVZ;
                    end else begin
                        we      = 1'b1;
                        waddr   = below_addr;
                        wdata   = bin_res;
                        top_n   = bin_res;
                        depth_n = r_depth - DW'(1);
                    end
                end
                OP_DUP: begin
                    if (!has1) begin
                        sts = STS_UNDER;
                    end else if (full) begin
                        sts = STS_OVER;
                    end else begin
                        we      = 1'b1;
                        wdata   = r_top;
                        depth_n = r_depth + DW'(1);
                    end
                end
                OP_JMP: begin
                    if (!tgt_ok) sts = STS_ADDR;
                    else pc_n = PW'(r_arg);
                end
                OP_JMPZ: begin
                    if (!has1) begin
                        sts = STS_UNDER;
                    end else if (!tgt_ok) begin
                        sts = STS_ADDR;
                    end else begin
                        if (r_top == '0) pc_n = PW'(r_arg);
                        top_n   = has2 ? rdata : '0;
                        depth_n = r_depth - DW'(1);
                    end
                end
                default: sts = STS_BADOP;
            endcase
        end
        // errors and the stopped answer leave pc, stack and top alone (an error still sets the stopped flag)
        if (sts != STS_OK && sts != STS_EXIT) begin
            pc_n    = r_pc;
            kind    = EMIT_NONE;
            emit    = '0;
            top_n   = r_top;
            depth_n = r_depth;
            we      = 1'b0;
        end
    end

    assign out_free        = !r_out_valid || i_out_ready;
    assign o_stat.div_need = !r_stopped && r_op == OP_DIV && has2 && r_top != '0;
    assign o_stat.div_done = div_done;
    assign o_stat.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_data.opcode;
            r_arg <= i_in_data.argument;
        end
        if (i_cmd.retire) begin
            r_out.status     <= sts;
            r_out.next_pc    <= NEXT_PC_W'(pc_n);
            r_out.emit_kind  <= kind;
            r_out.emit_value <= emit;
            r_out.top_value  <= top_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_pc        <= '0;
            r_stopped   <= 1'b0;
            r_top       <= '0;
            r_prog_len  <= CFG_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_prog_len <= i_cfg_data;
            end
            if (i_cmd.retire) begin
                r_out_valid <= 1'b1;
                r_pc        <= pc_n;
                r_top       <= top_n;
                r_depth     <= depth_n;
                if (sts != STS_OK) begin
                    r_stopped <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DW'(STACK_DEPTH))
        else $error("stack depth above capacity");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth == '0 |-> r_top == '0)
        else $error("empty stack with nonzero top");

    a_frozen_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.retire && r_stopped) |=> ($stable(r_pc) && $stable(r_depth)))
        else $error("state changed while stopped");

endmodule

FILE: rtl/stack_machine_execute.sv
// Stack-machine executor: one instruction per input beat, one result beat each.
// Each instruction is latched on accept, executed in CS_EXEC (div also waits in CS_DIV
// for the divider, one quotient bit per cycle) and retired in CS_RETIRE once the output
// register is free; one item in flight, no new instruction is accepted until retire.
// Synchronous active-low reset: empty stack, pc 0, running, program_length 1.
// Depends on sme_pkg, sme_ctrl, sme_datapath.
module stack_machine_execute
    import sme_pkg::*;
#(
    parameter int STACK_DEPTH   = STACK_DEPTH_D,
    parameter int PROGRAM_DEPTH = PROG_DEPTH_D
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    sme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sme_datapath #(
        .STACK_DEPTH   (STACK_DEPTH),
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
